/* rtl/core/ttb_pkg.sv */
// Shared types and constants for the timestamp timer bank.
// Used by the stopwatch bank, the countdown bank and the top level.
package ttb_pkg;

    // Channel field is 3 bits wide, so at most eight lanes of either kind.
    localparam int TTB_MAX_CHANNELS   = 8;
    localparam int TTB_WATCH_CHANNELS = 4;
    localparam int TTB_COUNT_CHANNELS = 4;

    // Command codes carried on the mode field.
    localparam logic [3:0] MODE_SW_RESET  = 4'd0;
    localparam logic [3:0] MODE_SW_START  = 4'd1;
    localparam logic [3:0] MODE_SW_STOP   = 4'd2;
    localparam logic [3:0] MODE_SW_READ   = 4'd3;
    localparam logic [3:0] MODE_CD_SET    = 4'd4;
    localparam logic [3:0] MODE_CD_RESET  = 4'd5;
    localparam logic [3:0] MODE_CD_START  = 4'd6;
    localparam logic [3:0] MODE_CD_PAUSE  = 4'd7;
    localparam logic [3:0] MODE_CD_ACK    = 4'd8;
    localparam logic [3:0] MODE_CD_READ   = 4'd9;
    localparam logic [3:0] MODE_POLL      = 4'd10;
    localparam logic [3:0] MODE_CLEAR_ALL = 4'd11;

    // One staged command, handed to both banks.
    typedef struct packed {
        logic        fire;
        logic [3:0]  mode;
        logic [2:0]  channel;
        logic [31:0] now_time;
        logic [31:0] duration;
    } cmd_t;

    typedef struct packed {
        logic [31:0] elapsed;
        logic        running;
    } watch_stat_t;

    typedef struct packed {
        logic [31:0] remaining;
        logic        running;
        logic        fired;
        logic [7:0]  expired;
    } count_stat_t;

endpackage

/* rtl/core/ttb_watch_bank.sv */
// Stopwatch lanes of the timer bank: state, command update and status.
// Depends on ttb_pkg for the command and status types.
module ttb_watch_bank
    import ttb_pkg::*;
#(
    parameter int WATCH_CHANNELS = TTB_WATCH_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output watch_stat_t stat
);

    logic [31:0] accum_reg [WATCH_CHANNELS];
    logic [31:0] start_reg [WATCH_CHANNELS];
    logic        run_reg   [WATCH_CHANNELS];
    logic [31:0] accum_next [WATCH_CHANNELS];
    logic [31:0] start_next [WATCH_CHANNELS];
    logic        run_next   [WATCH_CHANNELS];
    logic [31:0] elapsed_w  [WATCH_CHANNELS];

    logic [31:0] elapsed_pad [TTB_MAX_CHANNELS];
    logic        run_pad     [TTB_MAX_CHANNELS];

    always_comb
    begin
        for (int i = 0; i < WATCH_CHANNELS; i++)
        begin
            elapsed_w[i]  = accum_reg[i] + (run_reg[i] ? (cmd.now_time - start_reg[i]) : 32'd0);
            accum_next[i] = accum_reg[i];
            start_next[i] = start_reg[i];
            run_next[i]   = run_reg[i];
            if (cmd.mode == MODE_CLEAR_ALL)
            begin
                accum_next[i] = '0;
                start_next[i] = '0;
                run_next[i]   = 1'b0;
            end
            else if (cmd.channel == 3'(i))
            begin
                unique case (cmd.mode)
                    MODE_SW_RESET:
                    begin
                        accum_next[i] = '0;
                        start_next[i] = '0;
                        run_next[i]   = 1'b0;
                    end
                    MODE_SW_START:
                    begin
                        if (!run_reg[i])
                        begin
                            start_next[i] = cmd.now_time;
                            run_next[i]   = 1'b1;
                        end
                    end
                    MODE_SW_STOP:
                    begin
                        if (run_reg[i])
                        begin
                            accum_next[i] = elapsed_w[i];
                            run_next[i]   = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WATCH_CHANNELS; i++)
            begin
                accum_reg[i] <= '0;
                start_reg[i] <= '0;
                run_reg[i]   <= 1'b0;
            end
        end
        else if (cmd.fire)
        begin
            for (int i = 0; i < WATCH_CHANNELS; i++)
            begin
                accum_reg[i] <= accum_next[i];
                start_reg[i] <= start_next[i];
                run_reg[i]   <= run_next[i];
            end
        end
    end

    // Absent lanes read as zero.
    for (genvar g = 0; g < TTB_MAX_CHANNELS; g++)
    begin : g_pad
        if (g < WATCH_CHANNELS)
        begin : g_live
            assign elapsed_pad[g] = elapsed_w[g];
            assign run_pad[g]     = run_next[g];
        end
        else
        begin : g_absent
            assign elapsed_pad[g] = '0;
            assign run_pad[g]     = 1'b0;
        end
    end

    // Start and stop leave the elapsed figure unchanged at this timestamp.
    always_comb
    begin
        if (cmd.mode == MODE_CLEAR_ALL || cmd.mode == MODE_SW_RESET)
            stat.elapsed = '0;
        else
            stat.elapsed = elapsed_pad[cmd.channel];
        stat.running = run_pad[cmd.channel];
    end

endmodule

/* rtl/core/ttb_count_bank.sv */
// Countdown lanes of the timer bank: state, command update, poll and status.
// Depends on ttb_pkg for the command and status types.
module ttb_count_bank
    import ttb_pkg::*;
#(
    parameter int COUNT_CHANNELS = TTB_COUNT_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output count_stat_t stat
);

    logic [31:0] length_reg [COUNT_CHANNELS];
    logic [31:0] left_reg   [COUNT_CHANNELS];
    logic [31:0] start_reg  [COUNT_CHANNELS];
    logic        run_reg    [COUNT_CHANNELS];
    logic        fire_reg   [COUNT_CHANNELS];
    logic [31:0] length_next [COUNT_CHANNELS];
    logic [31:0] left_next   [COUNT_CHANNELS];
    logic [31:0] start_next  [COUNT_CHANNELS];
    logic        run_next    [COUNT_CHANNELS];
    logic        fire_next   [COUNT_CHANNELS];
    logic [31:0] gone_w      [COUNT_CHANNELS];
    logic [31:0] left_w      [COUNT_CHANNELS];
    logic        expire_w    [COUNT_CHANNELS];

    logic [31:0] left_pad   [TTB_MAX_CHANNELS];
    logic [31:0] length_pad [TTB_MAX_CHANNELS];
    logic        run_pad    [TTB_MAX_CHANNELS];
    logic        fire_pad   [TTB_MAX_CHANNELS];
    logic [7:0]  expire_pad;
    logic        present;

    always_comb
    begin
        for (int i = 0; i < COUNT_CHANNELS; i++)
        begin
            gone_w[i]   = cmd.now_time - start_reg[i];
            if (!run_reg[i])
                left_w[i] = left_reg[i];
            else if (gone_w[i] >= left_reg[i])
                left_w[i] = '0;
            else
                left_w[i] = left_reg[i] - gone_w[i];
            expire_w[i] = run_reg[i] && (left_w[i] == '0);

            length_next[i] = length_reg[i];
            left_next[i]   = left_reg[i];
            start_next[i]  = start_reg[i];
            run_next[i]    = run_reg[i];
            fire_next[i]   = fire_reg[i];

            if (cmd.mode == MODE_CLEAR_ALL)
            begin
                length_next[i] = '0;
                left_next[i]   = '0;
                start_next[i]  = '0;
                run_next[i]    = 1'b0;
                fire_next[i]   = 1'b0;
            end
            else if (cmd.mode == MODE_POLL)
            begin
                if (expire_w[i])
                begin
                    left_next[i] = '0;
                    run_next[i]  = 1'b0;
                    fire_next[i] = 1'b1;
                end
            end
            else if (cmd.channel == 3'(i))
            begin
                unique case (cmd.mode)
                    MODE_CD_SET:
                    begin
                        length_next[i] = cmd.duration;
                        left_next[i]   = cmd.duration;
                        start_next[i]  = '0;
                        run_next[i]    = 1'b0;
                        fire_next[i]   = 1'b0;
                    end
                    MODE_CD_RESET:
                    begin
                        left_next[i]  = length_reg[i];
                        start_next[i] = '0;
                        run_next[i]   = 1'b0;
                        fire_next[i]  = 1'b0;
                    end
                    MODE_CD_START:
                    begin
                        if (!run_reg[i] && left_reg[i] != '0)
                        begin
                            start_next[i] = cmd.now_time;
                            run_next[i]   = 1'b1;
                        end
                    end
                    MODE_CD_PAUSE:
                    begin
                        if (run_reg[i])
                        begin
                            left_next[i] = left_w[i];
                            run_next[i]  = 1'b0;
                        end
                    end
                    MODE_CD_ACK:
                        fire_next[i] = 1'b0;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COUNT_CHANNELS; i++)
            begin
                length_reg[i] <= '0;
                left_reg[i]   <= '0;
                start_reg[i]  <= '0;
                run_reg[i]    <= 1'b0;
                fire_reg[i]   <= 1'b0;
            end
        end
        else if (cmd.fire)
        begin
            for (int i = 0; i < COUNT_CHANNELS; i++)
            begin
                length_reg[i] <= length_next[i];
                left_reg[i]   <= left_next[i];
                start_reg[i]  <= start_next[i];
                run_reg[i]    <= run_next[i];
                fire_reg[i]   <= fire_next[i];
            end
        end
    end

    // Absent lanes read as zero.
    for (genvar g = 0; g < TTB_MAX_CHANNELS; g++)
    begin : g_pad
        if (g < COUNT_CHANNELS)
        begin : g_live
            assign left_pad[g]   = left_w[g];
            assign length_pad[g] = length_reg[g];
            assign run_pad[g]    = run_next[g];
            assign fire_pad[g]   = fire_next[g];
            assign expire_pad[g] = expire_w[g];
        end
        else
        begin : g_absent
            assign left_pad[g]   = '0;
            assign length_pad[g] = '0;
            assign run_pad[g]    = 1'b0;
            assign fire_pad[g]   = 1'b0;
            assign expire_pad[g] = 1'b0;
        end
    end

    assign present = {1'b0, cmd.channel} < 4'(COUNT_CHANNELS);

    // Start, pause, ack and poll leave the remaining time at this timestamp
    // as it was; only set, reset and clear change it.
    always_comb
    begin
        if (cmd.mode == MODE_CLEAR_ALL)
            stat.remaining = '0;
        else if (cmd.mode == MODE_CD_SET)
            stat.remaining = present ? cmd.duration : 32'd0;
        else if (cmd.mode == MODE_CD_RESET)
            stat.remaining = length_pad[cmd.channel];
        else
            stat.remaining = left_pad[cmd.channel];
        stat.running = run_pad[cmd.channel];
        stat.fired   = fire_pad[cmd.channel];
        stat.expired = (cmd.mode == MODE_POLL) ? expire_pad : 8'd0;
    end

endmodule

/* rtl/core/timestamp_timer_bank.sv */
// Top level of the timestamp timer bank: command stage, result stage, handshakes.
// Depends on ttb_pkg, ttb_watch_bank and ttb_count_bank.
//
//   channel   direction  handshake              payload
//   command   in         in_valid / in_ready    mode, channel, now_time, duration
//   status    out        out_valid / out_ready  elapsed_out, watch_running,
//                                               remaining_out, count_running,
//                                               count_fired, expired_mask
//
// One command per cycle while the status side keeps up: a transferred command
// enters the command register, which feeds the status register through the lane logic.
// The limit is the single pass through the lane update logic (subtract and
// compare per countdown lane on poll). rst_n clears every lane and both
// stages. When the status register is held by out_ready low, the command
// stage holds one more command, then in_ready drops.
module timestamp_timer_bank
    import ttb_pkg::*;
#(
    parameter int WATCH_CHANNELS = TTB_WATCH_CHANNELS,
    parameter int COUNT_CHANNELS = TTB_COUNT_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  mode,
    input  logic [2:0]  channel,
    input  logic [31:0] now_time,
    input  logic [31:0] duration,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] elapsed_out,
    output logic        watch_running,
    output logic [31:0] remaining_out,
    output logic        count_running,
    output logic        count_fired,
    output logic [7:0]  expired_mask
);

    logic        cmd_valid_reg;
    logic [3:0]  mode_reg;
    logic [2:0]  channel_reg;
    logic [31:0] now_reg;
    logic [31:0] dur_reg;
    logic        out_valid_reg;
    logic        advance;
    cmd_t        cmd;
    watch_stat_t watch_stat;
    count_stat_t count_stat;

    // Move the staged command into the status register, updating lane state.
    assign advance  = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (in_ready)
            cmd_valid_reg <= in_valid;
    end

    // Command payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg    <= mode;
            channel_reg <= channel;
            now_reg     <= now_time;
            dur_reg     <= duration;
        end
    end

    assign cmd.fire     = advance;
    assign cmd.mode     = mode_reg;
    assign cmd.channel  = channel_reg;
    assign cmd.now_time = now_reg;
    assign cmd.duration = dur_reg;

    ttb_watch_bank #(
        .WATCH_CHANNELS(WATCH_CHANNELS)
    ) u_watch (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .stat (watch_stat)
    );

    ttb_count_bank #(
        .COUNT_CHANNELS(COUNT_CHANNELS)
    ) u_count (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .stat (count_stat)
    );

    // Status register: valid drops once its transfer completes with nothing behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            elapsed_out   <= watch_stat.elapsed;
            watch_running <= watch_stat.running;
            remaining_out <= count_stat.remaining;
            count_running <= count_stat.running;
            count_fired   <= count_stat.fired;
            expired_mask  <= count_stat.expired;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/ttb_checker.sv */
// Port-level checks for the timestamp timer bank, bound to the top level.
// Depends on ttb_pkg and the timestamp_timer_bank ports.
module ttb_checker
    import ttb_pkg::*;
#(
    parameter int COUNT_CHANNELS = TTB_COUNT_CHANNELS
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [3:0]  mode,
    input logic [2:0]  channel,
    input logic [31:0] now_time,
    input logic [31:0] duration,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] elapsed_out,
    input logic        watch_running,
    input logic [31:0] remaining_out,
    input logic        count_running,
    input logic        count_fired,
    input logic [7:0]  expired_mask
);

    // Hold a stalled command transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(channel)
            && $stable(now_time) && $stable(duration))
    else $error("command changed while stalled");

    // Hold a stalled status transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(elapsed_out)
            && $stable(remaining_out) && $stable(expired_mask)
            && $stable(watch_running) && $stable(count_running) && $stable(count_fired))
    else $error("status changed while stalled");

    // Stall commands only when the status side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("command side stalled without a held status");

    // A fired countdown sits at zero and is stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_fired |-> remaining_out == 32'd0 && !count_running)
    else $error("fired countdown still holds time or runs");

    // Expire mask names present countdown lanes only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (16'(expired_mask) >> COUNT_CHANNELS) == 16'd0)
    else $error("expire mask names an absent lane");

endmodule

bind timestamp_timer_bank ttb_checker #(.COUNT_CHANNELS(COUNT_CHANNELS)) u_ttb_checker (.*);

/* dv/timestamp_timer_bank_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for timestamp_timer_bank: stopwatch and countdown commands
// checked against an in-bench model of the timer lanes. Depends on ttb_pkg and the RTL.
module timestamp_timer_bank_tb;

    import ttb_pkg::*;

    localparam int NW = TTB_WATCH_CHANNELS;
    localparam int NC = TTB_COUNT_CHANNELS;

    // Highest mode code; codes above clear all are unused by the block.
    localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

    // Cycles with no transfer on either side before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Extra cycles after the last status, to catch a stray transfer.
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [31:0] elapsed;
        logic        watch_run;
        logic [31:0] remaining;
        logic        count_run;
        logic        fired;
        logic [7:0]  mask;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  mode;
    logic [2:0]  channel;
    logic [31:0] now_time;
    logic [31:0] duration;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] elapsed_out;
    logic        watch_running;
    logic [31:0] remaining_out;
    logic        count_running;
    logic        count_fired;
    logic [7:0]  expired_mask;

    timestamp_timer_bank i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .channel       (channel),
        .now_time      (now_time),
        .duration      (duration),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .elapsed_out   (elapsed_out),
        .watch_running (watch_running),
        .remaining_out (remaining_out),
        .count_running (count_running),
        .count_fired   (count_fired),
        .expired_mask  (expired_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Timer lane model: one copy of every lane's state, advanced on each
    // accepted command transfer.
    // ------------------------------------------------------------------
    logic [31:0] sw_accum [NW];
    logic [31:0] sw_start [NW];
    logic        sw_run   [NW];
    logic [31:0] cd_len   [NC];
    logic [31:0] cd_left  [NC];
    logic [31:0] cd_start [NC];
    logic        cd_run   [NC];
    logic        cd_fire  [NC];

    status_t     status_q [$];   // expected status, oldest first
    status_t     head_status;
    int          errors;
    int          work_items;     // commands that act on some lane
    int          stall_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_len;       // receiver hold-off request, in cycles
    logic [31:0] clock_ms;       // running timestamp used by the stimulus

    function automatic logic [31:0] watch_elapsed(int c, logic [31:0] now);
        return sw_accum[c] + (sw_run[c] ? now - sw_start[c] : 32'd0);
    endfunction

    // Remaining countdown time, clamped at zero once the lane has run out.
    function automatic logic [31:0] count_remaining(int c, logic [31:0] now);
        logic [31:0] gone;
        if (!cd_run[c])
            return cd_left[c];
        gone = now - cd_start[c];
        return (gone >= cd_left[c]) ? 32'd0 : cd_left[c] - gone;
    endfunction

    function automatic void rearm_countdown(int c);
        cd_left[c]  = cd_len[c];
        cd_start[c] = '0;
        cd_run[c]   = 1'b0;
        cd_fire[c]  = 1'b0;
    endfunction

    function automatic void clear_timers();
        for (int i = 0; i < NW; i++)
        begin
            sw_accum[i] = '0;
            sw_start[i] = '0;
            sw_run[i]   = 1'b0;
        end
        for (int i = 0; i < NC; i++)
        begin
            cd_len[i] = '0;
            rearm_countdown(i);
        end
    endfunction

    // Apply one command to the lane model and return the status it reports.
    function automatic status_t predict_status(logic [3:0] m, logic [2:0] c,
                                               logic [31:0] now, logic [31:0] dur);
        status_t    s;
        int         ch;
        logic       w_ok;
        logic       c_ok;
        logic [7:0] mask;
        ch   = int'(c);
        w_ok = ch < NW;
        c_ok = ch < NC;
        mask = '0;
        s    = '0;
        if (m <= MODE_SW_READ && w_ok)
        begin
            case (m)
                MODE_SW_RESET:
                begin
                    sw_accum[ch] = '0;
                    sw_start[ch] = '0;
                    sw_run[ch]   = 1'b0;
                end
                MODE_SW_START:
                    if (!sw_run[ch])
                    begin
                        sw_start[ch] = now;
                        sw_run[ch]   = 1'b1;
                    end
                MODE_SW_STOP:
                    if (sw_run[ch])
                    begin
                        sw_accum[ch] = sw_accum[ch] + (now - sw_start[ch]);
                        sw_run[ch]   = 1'b0;
                    end
                default: ;
            endcase
        end
        else if (m >= MODE_CD_SET && m <= MODE_CD_READ && c_ok)
        begin
            case (m)
                MODE_CD_SET:
                begin
                    cd_len[ch] = dur;
                    rearm_countdown(ch);
                end
                MODE_CD_RESET:
                    rearm_countdown(ch);
                MODE_CD_START:
                    if (!cd_run[ch] && cd_left[ch] != 0)
                    begin
                        cd_start[ch] = now;
                        cd_run[ch]   = 1'b1;
                    end
                MODE_CD_PAUSE:
                    if (cd_run[ch])
                    begin
                        cd_left[ch] = count_remaining(ch, now);
                        cd_run[ch]  = 1'b0;
                    end
                MODE_CD_ACK:
                    cd_fire[ch] = 1'b0;
                default: ;
            endcase
        end
        else if (m == MODE_POLL)
        begin
            for (int i = 0; i < NC; i++)
                if (cd_run[i] && count_remaining(i, now) == 0)
                begin
                    cd_left[i] = '0;
                    cd_run[i]  = 1'b0;
                    cd_fire[i] = 1'b1;
                    mask[i]    = 1'b1;
                end
        end
        else if (m == MODE_CLEAR_ALL)
            clear_timers();

        if (w_ok)
        begin
            s.elapsed   = watch_elapsed(ch, now);
            s.watch_run = sw_run[ch];
        end
        if (c_ok)
        begin
            s.remaining = count_remaining(ch, now);
            s.count_run = cd_run[ch];
            s.fired     = cd_fire[ch];
        end
        s.mask = mask;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Each call starts at a rising edge; it may idle first,
    // then holds valid and the payload until the transfer happens, and
    // records the expected status at that edge. Valid is touched once per
    // edge, so back-to-back commands keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [3:0] m, input logic [2:0] c,
                            input logic [31:0] t, input logic [31:0] d);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        mode     <= m;
        channel  <= c;
        now_time <= t;
        duration <= d;
        do
            @(posedge clk);
        while (!in_ready);
        status_q.push_back(predict_status(m, c, t, d));
        // Commands to absent lanes and unused codes only report status.
        if ((m <= MODE_SW_READ && c < NW) ||
            (m >= MODE_CD_SET && m <= MODE_CD_READ && c < NC) ||
            m == MODE_POLL || m == MODE_CLEAR_ALL)
            work_items++;
    endtask

    // Drop valid and hold the command side until every expected status
    // has come back.
    task automatic wait_for_status();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    // Move the stimulus clock: mostly small steps, now and then a jump
    // anywhere or to just below the wrap point.
    function automatic void advance_clock(int span);
        int r;
        r = $urandom_range(99);
        if (r == 0)
            clock_ms = $urandom;
        else if (r == 1)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(60);
        else
            clock_ms = clock_ms + $urandom_range(span);
    endfunction

    function automatic logic [31:0] countdown_length();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    // Short command sequence on one live lane, or a run of random commands on live lanes.
    task automatic run_scenario();
        logic [2:0] c;
        logic [3:0] m;
        int         steps;
        c     = 3'($urandom_range(NC - 1));
        steps = $urandom_range(2, 6);
        case ($urandom_range(2))
            0:
            begin
                send_cmd(MODE_SW_START, c, clock_ms, $urandom);
                repeat (steps)
                begin
                    advance_clock(50);
                    m = 4'($urandom_range(MODE_SW_RESET, MODE_SW_READ));
                    send_cmd(m, c, clock_ms, $urandom);
                end
                advance_clock(50);
                send_cmd(MODE_SW_STOP, c, clock_ms, $urandom);
            end
            1:
            begin
                send_cmd(MODE_CD_SET, c, clock_ms, countdown_length());
                advance_clock(10);
                send_cmd(MODE_CD_START, c, clock_ms, $urandom);
                repeat (steps)
                begin
                    advance_clock(40);
                    if ($urandom_range(3) == 0)
                        m = 4'($urandom_range(MODE_CD_SET, MODE_CD_READ));
                    else
                        m = MODE_POLL;
                    send_cmd(m, c, clock_ms, countdown_length());
                end
                send_cmd(MODE_CD_ACK, c, clock_ms, $urandom);
            end
            default:
                repeat (steps)
                begin
                    advance_clock(20);
                    m = 4'($urandom_range(MODE_SW_RESET, MODE_CLEAR_ALL));
                    c = 3'($urandom_range(NC - 1));
                    send_cmd(m, c, clock_ms, countdown_length());
                end
        endcase
    endtask

    // Anything the fields allow: unused codes, absent lanes, any timestamp.
    task automatic send_noise();
        logic [31:0] t;
        t = $urandom_range(1) ? $urandom : clock_ms;
        send_cmd(4'($urandom_range(MODE_UNUSED_TOP)), 3'($urandom_range(7)), t, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_cmd(MODE_SW_READ,   3'd0, 32'd0,          32'd0);
        // Stopwatch run across the timestamp wrap: 0x20 ms elapsed.
        send_cmd(MODE_SW_START,  3'd0, 32'hFFFF_FFF0,  32'd0);
        send_cmd(MODE_SW_START,  3'd0, 32'h0000_0005,  32'd0);  // already running
        send_cmd(MODE_SW_READ,   3'd0, 32'h0000_0008,  32'd0);
        send_cmd(MODE_SW_STOP,   3'd0, 32'h0000_0010,  32'd0);
        send_cmd(MODE_SW_STOP,   3'd0, 32'h0000_0020,  32'd0);  // already stopped
        send_cmd(MODE_SW_RESET,  3'd0, 32'h0000_0030,  32'd0);
        // Start on an empty countdown does nothing.
        send_cmd(MODE_CD_SET,    3'd1, 32'd0,          32'd0);
        send_cmd(MODE_CD_START,  3'd1, 32'd64,         32'd0);
        // Run, pause, resume and expire a 100 ms countdown.
        send_cmd(MODE_CD_SET,    3'd1, 32'd80,         32'd100);
        send_cmd(MODE_CD_START,  3'd1, 32'd1000,       32'd0);
        send_cmd(MODE_CD_PAUSE,  3'd1, 32'd1060,       32'd0);
        send_cmd(MODE_CD_PAUSE,  3'd1, 32'd1070,       32'd0);  // already paused
        send_cmd(MODE_CD_START,  3'd1, 32'd2000,       32'd0);
        send_cmd(MODE_POLL,      3'd0, 32'd2030,       32'd0);
        send_cmd(MODE_POLL,      3'd1, 32'd2040,       32'd0);
        send_cmd(MODE_CD_ACK,    3'd1, 32'd2050,       32'd0);
        // Longest countdown, read once the timestamp has gone all the way round.
        send_cmd(MODE_CD_SET,    3'd3, 32'd0,          32'hFFFF_FFFF);
        send_cmd(MODE_CD_START,  3'd3, 32'd5,          32'd0);
        send_cmd(MODE_CD_READ,   3'd3, 32'd4,          32'd0);
        send_cmd(MODE_POLL,      3'd3, 32'd4,          32'd0);
        send_cmd(MODE_CD_RESET,  3'd3, 32'd6,          32'd0);
        // Absent lanes and an unused code.
        send_cmd(MODE_SW_START,  3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_cmd(MODE_CD_SET,    3'd5, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_cmd(MODE_UNUSED_TOP, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_CLEAR_ALL, 3'd2, 32'd0,          32'd0);
    endtask

    // Long receiver hold-off while commands keep coming: the block fills
    // its two stages and drops in_ready until the hold ends.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len    = 60;
        repeat (16)
        begin
            advance_clock(20);
            send_cmd(4'($urandom_range(MODE_SW_RESET, MODE_POLL)), 3'($urandom_range(NC - 1)),
                     clock_ms, countdown_length());
        end
    endtask

    // Let the block run dry between two bursts.
    task automatic test_drain_pause();
        repeat (2)
        begin
            run_scenario();
            wait_for_status();
        end
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        int goal;
        goal        = work_items + n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (work_items < goal)
            if ($urandom_range(99) < 70)
                run_scenario();
            else
                send_noise();
    endtask

    // ------------------------------------------------------------------
    // Status side: random out_ready, or a counted hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                hold_len--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Compare every status transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected status, expected none actual %h %b %h %b %b %h",
                         $time, elapsed_out, watch_running, remaining_out,
                         count_running, count_fired, expired_mask);
            end
            else
            begin
                head_status = status_q.pop_front();
                check_field("elapsed_out",   head_status.elapsed,   elapsed_out);
                check_field("watch_running", 32'(head_status.watch_run),
                            32'(watch_running));
                check_field("remaining_out", head_status.remaining, remaining_out);
                check_field("count_running", 32'(head_status.count_run),
                            32'(count_running));
                check_field("count_fired",   32'(head_status.fired), 32'(count_fired));
                check_field("expired_mask",  32'(head_status.mask),  32'(expired_mask));
            end
        end
    end

    // Watchdog: end the run if neither side transfers for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        errors      = 0;
        work_items  = 0;
        stall_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len    = 0;
        clock_ms    = '0;
        clear_timers();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_SW_RESET;
        channel  <= '0;
        now_time <= '0;
        duration <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(340, 38, 59);
        test_random(340, 59, 38);
        test_random(350, 0, 0);

        // Drop valid, drain, then keep watching for stray status.
        wait_for_status();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
